// ===== sv/lpa_pkg.sv =====
`default_nettype none
package lpa_pkg;

  // Field and register widths
  localparam int DataW    = 32;  // Q16.16 input and accel words
  localparam int FracW    = 16;  // fraction bits of Q16.16
  localparam int LenW     = 31;  // leash and velocity limits, clamped magnitudes
  localparam int GainW    = 18;  // loop gains
  localparam int AngW     = 17;  // attitude limits
  localparam int CmdW     = 18;  // attitude commands
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 31;

  // Internal widths
  localparam int MagW   = DataW + 1;       // error magnitude into a clamp unit
  localparam int AccW   = DataW + 2;       // acceleration magnitude
  localparam int SumW   = 2 * LenW + 1;    // a*a + b*b
  localparam int RootW  = LenW + 1;        // floor(sqrt(sum))
  localparam int DivW   = 2 * LenW;        // lim * component
  localparam int TiltW  = AccW + FracW;    // accel magnitude << 16
  localparam int TiltQW = AngW + 1;        // tilt quotient bits before saturation

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegLeash      = 3'd0;
  localparam logic [CfgIdxW-1:0] RegVelLimit   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPosGain    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegVelGain    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRollLimit  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegPitchLimit = 3'd5;

  // Reset values
  localparam logic [LenW-1:0]  LeashReset    = 31'd131072;
  localparam logic [LenW-1:0]  VelLimitReset = 31'd137626;
  localparam logic [GainW-1:0] PosGainReset  = 18'd16384;
  localparam logic [GainW-1:0] VelGainReset  = 18'd49152;
  localparam logic [AngW-1:0]  RollReset     = 17'd13107;
  localparam logic [AngW-1:0]  PitchReset    = 17'd13107;

endpackage
`default_nettype wire

// ===== sv/lpa_if.sv =====
`default_nettype none
interface lpa_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [lpa_pkg::DataW-1:0] target_x;
  logic signed [lpa_pkg::DataW-1:0] target_y;
  logic signed [lpa_pkg::DataW-1:0] position_x;
  logic signed [lpa_pkg::DataW-1:0] position_y;
  logic signed [lpa_pkg::DataW-1:0] velocity_x;
  logic signed [lpa_pkg::DataW-1:0] velocity_y;
  logic signed [lpa_pkg::DataW-1:0] thrust_z;

  modport source (output valid, target_x, target_y, position_x, position_y,
                  velocity_x, velocity_y, thrust_z, input ready);
  modport sink (input valid, target_x, target_y, position_x, position_y,
                velocity_x, velocity_y, thrust_z, output ready);
endinterface

interface lpa_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [lpa_pkg::DataW-1:0] accel_x;
  logic signed [lpa_pkg::DataW-1:0] accel_y;
  logic signed [lpa_pkg::CmdW-1:0]  roll_command;
  logic signed [lpa_pkg::CmdW-1:0]  pitch_command;
  logic                            zero_thrust;

  modport source (output valid, accel_x, accel_y, roll_command, pitch_command,
                  zero_thrust, input ready);
  modport sink (input valid, accel_x, accel_y, roll_command, pitch_command,
                zero_thrust, output ready);
endinterface
`default_nettype wire

// ===== sv/lpa_clamp.sv =====
`default_nettype none
// Vector magnitude clamp: wide halving, squares, sum, one sqrt bit per stage,
// then one quotient bit per stage for both components.
module lpa_clamp #(
  parameter int SideW = 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      en,
  input  wire logic                      strict,
  input  wire logic                      in_valid,
  input  wire logic [lpa_pkg::MagW-1:0]  a_in,
  input  wire logic [lpa_pkg::MagW-1:0]  b_in,
  input  wire logic [lpa_pkg::LenW-1:0]  lim,
  input  wire logic [SideW-1:0]          side_in,
  output logic                           out_valid,
  output logic [lpa_pkg::LenW-1:0]       a_out,
  output logic [lpa_pkg::LenW-1:0]       b_out,
  output logic [SideW-1:0]               side_out
);

  localparam int MagW   = lpa_pkg::MagW;
  localparam int LenW   = lpa_pkg::LenW;
  localparam int SumW   = lpa_pkg::SumW;
  localparam int RootW  = lpa_pkg::RootW;
  localparam int DivW   = lpa_pkg::DivW;
  localparam int SqW    = SumW + 1;
  localparam int ShiftN = MagW - LenW;
  localparam int RootN  = RootW;
  localparam int DivN   = LenW;

  typedef struct packed {
    logic [SqW-1:0] x;
    logic [SqW-1:0] r;
  } sq_t;

  function automatic sq_t sqrt_step(input sq_t s, input int k);
    logic [SqW-1:0] bitv;
    logic [SqW-1:0] trial;
    sq_t            o;
    bitv  = SqW'(1) << (2 * k);
    trial = s.r + bitv;
    if (s.x >= trial) begin
      o.x = s.x - trial;
      o.r = (s.r >> 1) + bitv;
    end else begin
      o.x = s.x;
      o.r = s.r >> 1;
    end
    return o;
  endfunction

  function automatic logic [DivW:0] div_step(input logic [DivW-1:0] rem,
                                             input logic [RootW-1:0] d, input int i);
    logic [DivW-1:0] trial;
    trial = DivW'(d) << i;
    if (rem >= trial) return {1'b1, rem - trial};
    else return {1'b0, rem};
  endfunction

  // halve both components until they fit the limit width
  logic [MagW-1:0] wa, wb;
  logic            ww;
  always_comb begin
    wa = a_in;
    wb = b_in;
    ww = 1'b0;
    for (int n = 0; n < ShiftN; n++) begin
      if (|((wa | wb) >> LenW)) begin
        wa = wa >> 1;
        wb = wb >> 1;
        ww = 1'b1;
      end
    end
  end

  logic              v1, v2, v3;
  logic [LenW-1:0]   a1, b1, a2, b2, a3, b3;
  logic              w1, w2, w3;
  logic [SideW-1:0]  side1, side2, side3;
  logic [DivW-1:0]   aa2, bb2, ll2, la2, lb2, ll3, la3, lb3;
  logic [SumW-1:0]   sum3;

  logic              sv    [RootN];
  sq_t               sq    [RootN];
  logic              sc    [RootN];
  logic [DivW-1:0]   sla   [RootN];
  logic [DivW-1:0]   slb   [RootN];
  logic [LenW-1:0]   sa    [RootN];
  logic [LenW-1:0]   sb    [RootN];
  logic [SideW-1:0]  sside [RootN];

  logic              dv    [DivN];
  logic [DivW-1:0]   rema  [DivN];
  logic [DivW-1:0]   remb  [DivN];
  logic [LenW-1:0]   qa    [DivN];
  logic [LenW-1:0]   qb    [DivN];
  logic [RootW-1:0]  dd    [DivN];
  logic              dc    [DivN];
  logic [LenW-1:0]   da    [DivN];
  logic [LenW-1:0]   db    [DivN];
  logic [SideW-1:0]  dside [DivN];

  logic [DivW:0]     na    [DivN];
  logic [DivW:0]     nb    [DivN];

  always_comb begin
    na[0] = div_step(sla[RootN-1], sq[RootN-1].r[RootW-1:0], LenW - 1);
    nb[0] = div_step(slb[RootN-1], sq[RootN-1].r[RootW-1:0], LenW - 1);
    for (int i = 1; i < DivN; i++) begin
      na[i] = div_step(rema[i-1], dd[i-1], LenW - 1 - i);
      nb[i] = div_step(remb[i-1], dd[i-1], LenW - 1 - i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      for (int j = 0; j < RootN; j++) sv[j] <= 1'b0;
      for (int i = 0; i < DivN; i++) dv[i] <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      sv[0] <= v3;
      for (int j = 1; j < RootN; j++) sv[j] <= sv[j-1];
      dv[0] <= sv[RootN-1];
      for (int i = 1; i < DivN; i++) dv[i] <= dv[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1    <= wa[LenW-1:0];
      b1    <= wb[LenW-1:0];
      w1    <= ww;
      side1 <= side_in;

      aa2   <= DivW'(a1) * DivW'(a1);
      bb2   <= DivW'(b1) * DivW'(b1);
      ll2   <= DivW'(lim) * DivW'(lim);
      la2   <= DivW'(lim) * DivW'(a1);
      lb2   <= DivW'(lim) * DivW'(b1);
      a2    <= a1;
      b2    <= b1;
      w2    <= w1;
      side2 <= side1;

      sum3  <= SumW'(aa2) + SumW'(bb2);
      ll3   <= ll2;
      la3   <= la2;
      lb3   <= lb2;
      a3    <= a2;
      b3    <= b2;
      w3    <= w2;
      side3 <= side2;

      sq[0]    <= sqrt_step('{x: SqW'(sum3), r: '0}, RootN - 1);
      sc[0]    <= w3 | (strict ? (sum3 > SumW'(ll3)) : (sum3 >= SumW'(ll3)));
      sla[0]   <= la3;
      slb[0]   <= lb3;
      sa[0]    <= a3;
      sb[0]    <= b3;
      sside[0] <= side3;
      for (int j = 1; j < RootN; j++) begin
        sq[j]    <= sqrt_step(sq[j-1], RootN - 1 - j);
        sc[j]    <= sc[j-1];
        sla[j]   <= sla[j-1];
        slb[j]   <= slb[j-1];
        sa[j]    <= sa[j-1];
        sb[j]    <= sb[j-1];
        sside[j] <= sside[j-1];
      end

      rema[0]  <= na[0][DivW-1:0];
      remb[0]  <= nb[0][DivW-1:0];
      qa[0]    <= LenW'(na[0][DivW]);
      qb[0]    <= LenW'(nb[0][DivW]);
      dd[0]    <= sq[RootN-1].r[RootW-1:0];
      dc[0]    <= sc[RootN-1];
      da[0]    <= sa[RootN-1];
      db[0]    <= sb[RootN-1];
      dside[0] <= sside[RootN-1];
      for (int i = 1; i < DivN; i++) begin
        rema[i]  <= na[i][DivW-1:0];
        remb[i]  <= nb[i][DivW-1:0];
        qa[i]    <= {qa[i-1][LenW-2:0], na[i][DivW]};
        qb[i]    <= {qb[i-1][LenW-2:0], nb[i][DivW]};
        dd[i]    <= dd[i-1];
        dc[i]    <= dc[i-1];
        da[i]    <= da[i-1];
        db[i]    <= db[i-1];
        dside[i] <= dside[i-1];
      end
    end
  end

  // pass through when inside the limit, zero for a zero-length vector
  always_comb begin
    out_valid = dv[DivN-1];
    side_out  = dside[DivN-1];
    if (!dc[DivN-1]) begin
      a_out = da[DivN-1];
      b_out = db[DivN-1];
    end else if (dd[DivN-1] == '0) begin
      a_out = '0;
      b_out = '0;
    end else begin
      a_out = qa[DivN-1];
      b_out = qb[DivN-1];
    end
  end

endmodule
`default_nettype wire

// ===== sv/lpa_tilt.sv =====
`default_nettype none
// Thrust-normalized tilt for two lanes: lane 0 roll, lane 1 pitch (unsigned sense).
// One quotient bit per stage, saturated to each lane's limit at the end.
module lpa_tilt #(
  parameter int SideW = 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              en,
  input  wire logic                              in_valid,
  input  wire logic [1:0]                        neg,
  input  wire logic [1:0][lpa_pkg::AccW-1:0]     mag,
  input  wire logic [lpa_pkg::DataW-1:0]         thrust,
  input  wire logic [1:0][lpa_pkg::AngW-1:0]     lim,
  input  wire logic [SideW-1:0]                  side_in,
  output logic                                   out_valid,
  output logic [1:0][lpa_pkg::CmdW-1:0]          cmd,
  output logic                                   zero,
  output logic [SideW-1:0]                       side_out
);

  localparam int LaneN = 2;
  localparam int DataW = lpa_pkg::DataW;
  localparam int AccW  = lpa_pkg::AccW;
  localparam int AngW  = lpa_pkg::AngW;
  localparam int CmdW  = lpa_pkg::CmdW;
  localparam int FracW = lpa_pkg::FracW;
  localparam int TW    = lpa_pkg::TiltW;
  localparam int QN    = lpa_pkg::TiltQW;

  function automatic logic [TW:0] tstep(input logic [TW-1:0] rem,
                                        input logic [DataW-1:0] t, input int i);
    logic [TW-1:0] trial;
    trial = TW'(t) << i;
    if (rem >= trial) return {1'b1, rem - trial};
    else return {1'b0, rem};
  endfunction

  logic                 pv;
  logic [TW-1:0]        prem [LaneN];
  logic [LaneN-1:0]     povf, pnz, pneg;
  logic [DataW-1:0]     pt;
  logic                 pz;
  logic [SideW-1:0]     pside;

  logic                 dv    [QN];
  logic [TW-1:0]        drem  [QN][LaneN];
  logic [QN-1:0]        dq    [QN][LaneN];
  logic [LaneN-1:0]     dovf  [QN];
  logic [LaneN-1:0]     dnz   [QN];
  logic [LaneN-1:0]     dneg  [QN];
  logic [DataW-1:0]     dt    [QN];
  logic                 dz    [QN];
  logic [SideW-1:0]     dside [QN];

  logic [TW:0]          nxt   [QN][LaneN];
  logic [AngW-1:0]      qq    [LaneN];

  always_comb begin
    for (int l = 0; l < LaneN; l++) begin
      nxt[0][l] = tstep(prem[l], pt, QN - 1);
      for (int i = 1; i < QN; i++) nxt[i][l] = tstep(drem[i-1][l], dt[i-1], QN - 1 - i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
      for (int i = 0; i < QN; i++) dv[i] <= 1'b0;
    end else if (en) begin
      pv    <= in_valid;
      dv[0] <= pv;
      for (int i = 1; i < QN; i++) dv[i] <= dv[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LaneN; l++) begin
        prem[l] <= TW'(mag[l]) << FracW;
        // quotient reaches 2^QN exactly when mag >= t << (QN - FracW)
        povf[l] <= mag[l] >= (AccW'(thrust) << (QN - FracW));
        pnz[l]  <= mag[l] != '0;
        pneg[l] <= neg[l];
      end
      pt    <= thrust;
      pz    <= thrust == '0;
      pside <= side_in;

      for (int l = 0; l < LaneN; l++) begin
        drem[0][l] <= nxt[0][l][TW-1:0];
        dq[0][l]   <= QN'(nxt[0][l][TW]);
      end
      dovf[0]  <= povf;
      dnz[0]   <= pnz;
      dneg[0]  <= pneg;
      dt[0]    <= pt;
      dz[0]    <= pz;
      dside[0] <= pside;
      for (int i = 1; i < QN; i++) begin
        for (int l = 0; l < LaneN; l++) begin
          drem[i][l] <= nxt[i][l][TW-1:0];
          dq[i][l]   <= {dq[i-1][l][QN-2:0], nxt[i][l][TW]};
        end
        dovf[i]  <= dovf[i-1];
        dnz[i]   <= dnz[i-1];
        dneg[i]  <= dneg[i-1];
        dt[i]    <= dt[i-1];
        dz[i]    <= dz[i-1];
        dside[i] <= dside[i-1];
      end
    end
  end

  // saturate, or take the limit by sign when thrust is zero
  always_comb begin
    out_valid = dv[QN-1];
    zero      = dz[QN-1];
    side_out  = dside[QN-1];
    for (int l = 0; l < LaneN; l++) begin
      if (dz[QN-1]) begin
        qq[l] = dnz[QN-1][l] ? lim[l] : '0;
      end else if (dovf[QN-1][l] || (dq[QN-1][l] > QN'(lim[l]))) begin
        qq[l] = lim[l];
      end else begin
        qq[l] = dq[QN-1][l][AngW-1:0];
      end
      cmd[l] = (dneg[QN-1][l] && dnz[QN-1][l]) ? (CmdW'(0) - CmdW'(qq[l])) : CmdW'(qq[l]);
    end
  end

endmodule
`default_nettype wire

// ===== sv/leashed_position_pd_to_attitude.sv =====
`default_nettype none
// Channel   Dir  Word                                                   Handshake
// req       in   target_x/y, position_x/y, velocity_x/y, thrust_z       valid/ready
// rsp       out  accel_x/y, roll_command, pitch_command, zero_thrust    valid/ready
// cfg       in   cfg_index, cfg_data                                    cfg_write, no wait
//
// One word enters per cycle unless a result waits. The pipe runs through the two
// clamp units (66 stages each: halving, squares, sum, a stage per sqrt bit, then
// one per quotient bit) and the 19-stage tilt divider. The whole pipe advances
// together: when a result sits unaccepted in the output register, every stage
// holds and req.ready drops. Reset clears all valid bits and loads the register
// defaults; nothing else needs a pass after reset.
module leashed_position_pd_to_attitude (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [lpa_pkg::CfgIdxW-1:0]    cfg_index,
  input  wire logic [lpa_pkg::CfgDataW-1:0]   cfg_data,
  lpa_in_if.sink                              req,
  lpa_out_if.source                           rsp
);

  localparam int DataW = lpa_pkg::DataW;
  localparam int FracW = lpa_pkg::FracW;
  localparam int LenW  = lpa_pkg::LenW;
  localparam int GainW = lpa_pkg::GainW;
  localparam int AngW  = lpa_pkg::AngW;
  localparam int CmdW  = lpa_pkg::CmdW;
  localparam int MagW  = lpa_pkg::MagW;
  localparam int AccW  = lpa_pkg::AccW;
  localparam int PgW   = LenW + GainW;      // clamped error times position gain
  localparam int VgW   = DataW + GainW;     // velocity error times velocity gain
  localparam int SideA = 2 + 3 * DataW;     // signs, velocity, thrust magnitude
  localparam int SideT = 2 * DataW;         // saturated accelerations
  localparam logic [CmdW-1:0] CmdMin = {1'b1, {(CmdW-1){1'b0}}};

  // Configuration registers
  logic [LenW-1:0]  leash_lim, velocity_limit;
  logic [GainW-1:0] position_gain, velocity_gain;
  logic [AngW-1:0]  roll_limit, pitch_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      leash_lim      <= lpa_pkg::LeashReset;
      velocity_limit <= lpa_pkg::VelLimitReset;
      position_gain  <= lpa_pkg::PosGainReset;
      velocity_gain  <= lpa_pkg::VelGainReset;
      roll_limit     <= lpa_pkg::RollReset;
      pitch_limit    <= lpa_pkg::PitchReset;
    end else if (cfg_write) begin
      case (cfg_index)
        lpa_pkg::RegLeash:      leash_lim      <= cfg_data[LenW-1:0];
        lpa_pkg::RegVelLimit:   velocity_limit <= cfg_data[LenW-1:0];
        lpa_pkg::RegPosGain:    position_gain  <= cfg_data[GainW-1:0];
        lpa_pkg::RegVelGain:    velocity_gain  <= cfg_data[GainW-1:0];
        lpa_pkg::RegRollLimit:  roll_limit     <= cfg_data[AngW-1:0];
        lpa_pkg::RegPitchLimit: pitch_limit    <= cfg_data[AngW-1:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // Global advance: hold everything while the output word waits
  logic ov;
  logic en;
  assign en        = !ov || rsp.ready;
  assign req.ready = en && !rst;

  // Stage 1: position error and thrust magnitude
  logic             v1;
  logic [MagW-1:0]  ex1, ey1;
  logic [DataW-1:0] vx1, vy1, t1;

  // Stage 2: error magnitudes and signs
  logic             v2;
  logic [MagW-1:0]  mx2, my2;
  logic             nx2, ny2;
  logic [DataW-1:0] vx2, vy2, t2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= req.valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ex1 <= {req.target_x[DataW-1], req.target_x} - {req.position_x[DataW-1], req.position_x};
      ey1 <= {req.target_y[DataW-1], req.target_y} - {req.position_y[DataW-1], req.position_y};
      vx1 <= req.velocity_x;
      vy1 <= req.velocity_y;
      t1  <= req.thrust_z[DataW-1] ? (~req.thrust_z + 1'b1) : req.thrust_z;

      mx2 <= ex1[MagW-1] ? (~ex1 + 1'b1) : ex1;
      my2 <= ey1[MagW-1] ? (~ey1 + 1'b1) : ey1;
      nx2 <= ex1[MagW-1];
      ny2 <= ey1[MagW-1];
      vx2 <= vx1;
      vy2 <= vy1;
      t2  <= t1;
    end
  end

  // Leash clamp: clamp at or beyond the leash length
  logic             c1v;
  logic [LenW-1:0]  c1a, c1b;
  logic [SideA-1:0] c1side;

  lpa_clamp #(.SideW(SideA)) u_leash (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .strict   (1'b0),
    .in_valid (v2),
    .a_in     (mx2),
    .b_in     (my2),
    .lim      (leash_lim),
    .side_in  ({nx2, ny2, vx2, vy2, t2}),
    .out_valid(c1v),
    .a_out    (c1a),
    .b_out    (c1b),
    .side_out (c1side)
  );

  // Stage 3: position gain
  logic             v3;
  logic [PgW-1:0]   px3, py3;
  logic [SideA-1:0] side3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= c1v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px3   <= PgW'(c1a) * PgW'(position_gain);
      py3   <= PgW'(c1b) * PgW'(position_gain);
      side3 <= c1side;
    end
  end

  // Velocity clamp: clamp only strictly above the limit
  logic             c2v;
  logic [LenW-1:0]  c2a, c2b;
  logic [SideA-1:0] c2side;

  lpa_clamp #(.SideW(SideA)) u_vlimit (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .strict   (1'b1),
    .in_valid (v3),
    .a_in     (px3[FracW +: MagW]),
    .b_in     (py3[FracW +: MagW]),
    .lim      (velocity_limit),
    .side_in  (side3),
    .out_valid(c2v),
    .a_out    (c2a),
    .b_out    (c2b),
    .side_out (c2side)
  );

  logic             c2nx, c2ny;
  logic [DataW-1:0] c2vx, c2vy, c2t;
  logic [MagW-1:0]  cx, cy;
  assign c2nx = c2side[SideA-1];
  assign c2ny = c2side[SideA-2];
  assign c2vx = c2side[3*DataW-1 -: DataW];
  assign c2vy = c2side[2*DataW-1 -: DataW];
  assign c2t  = c2side[DataW-1:0];
  assign cx   = c2nx ? (MagW'(0) - MagW'(c2a)) : MagW'(c2a);
  assign cy   = c2ny ? (MagW'(0) - MagW'(c2b)) : MagW'(c2b);

  // Stages 4 to 6: velocity error, magnitude, velocity gain
  logic             v4, v5, v6;
  logic [MagW-1:0]  dx4, dy4;
  logic [DataW-1:0] t4, t5, t6;
  logic [DataW-1:0] mx5, my5;
  logic             nx5, ny5, nx6, ny6;
  logic [VgW-1:0]   ax6, ay6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v4 <= c2v;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx4 <= cx - {c2vx[DataW-1], c2vx};
      dy4 <= cy - {c2vy[DataW-1], c2vy};
      t4  <= c2t;

      // the velocity error magnitude always fits the data width
      mx5 <= dx4[MagW-1] ? DataW'(~dx4 + 1'b1) : dx4[DataW-1:0];
      my5 <= dy4[MagW-1] ? DataW'(~dy4 + 1'b1) : dy4[DataW-1:0];
      nx5 <= dx4[MagW-1];
      ny5 <= dy4[MagW-1];
      t5  <= t4;

      ax6 <= VgW'(mx5) * VgW'(velocity_gain);
      ay6 <= VgW'(my5) * VgW'(velocity_gain);
      nx6 <= nx5;
      ny6 <= ny5;
      t6  <= t5;
    end
  end

  // Saturate accelerations to the word range
  logic [AccW-1:0]  amx, amy;
  logic [DataW-1:0] sat_x, sat_y;
  localparam logic [AccW-1:0] PosMax = AccW'({1'b0, {(DataW-1){1'b1}}});
  localparam logic [AccW-1:0] NegMax = AccW'({1'b1, {(DataW-1){1'b0}}});
  assign amx = ax6[FracW +: AccW];
  assign amy = ay6[FracW +: AccW];

  always_comb begin
    if (!nx6) sat_x = (amx > PosMax) ? PosMax[DataW-1:0] : amx[DataW-1:0];
    else      sat_x = (amx > NegMax) ? NegMax[DataW-1:0] : (~amx[DataW-1:0] + 1'b1);
    if (!ny6) sat_y = (amy > PosMax) ? PosMax[DataW-1:0] : amy[DataW-1:0];
    else      sat_y = (amy > NegMax) ? NegMax[DataW-1:0] : (~amy[DataW-1:0] + 1'b1);
  end

  // Tilt: lane 0 roll from ay, lane 1 pitch from ax (negated below)
  logic                 tv;
  logic [1:0][CmdW-1:0] tcmd;
  logic                 tzero;
  logic [SideT-1:0]     tside;

  lpa_tilt #(.SideW(SideT)) u_tilt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v6),
    .neg      ({nx6, ny6}),
    .mag      ({amx, amy}),
    .thrust   (t6),
    .lim      ({pitch_limit, roll_limit}),
    .side_in  ({sat_x, sat_y}),
    .out_valid(tv),
    .cmd      (tcmd),
    .zero     (tzero),
    .side_out (tside)
  );

  // Output register
  logic [DataW-1:0] acc_x_q, acc_y_q;
  logic [CmdW-1:0]  roll_q, pitch_q;
  logic             zero_q;

  always_ff @(posedge clk) begin
    if (rst) ov <= 1'b0;
    else if (en) ov <= tv;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_x_q <= tside[SideT-1 -: DataW];
      acc_y_q <= tside[DataW-1:0];
      roll_q  <= tcmd[0];
      pitch_q <= CmdW'(0) - tcmd[1];
      zero_q  <= tzero;
    end
  end

  assign rsp.valid         = ov;
  assign rsp.accel_x       = acc_x_q;
  assign rsp.accel_y       = acc_y_q;
  assign rsp.roll_command  = roll_q;
  assign rsp.pitch_command = pitch_q;
  assign rsp.zero_thrust   = zero_q;

  // A waiting result must hold the whole pipe, input side included
  a_stall_holds_input: assert property (@(posedge clk)
    rsp.valid && !rsp.ready |-> !req.ready)
    else $error("input accepted while output stalled");

  // Attitude limits never exceed 17 bits, so the most negative code never appears
  a_cmd_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.roll_command != CmdMin) && (rsp.pitch_command != CmdMin))
    else $error("attitude command out of range");

  // Synchronous reset empties the output register
  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !rsp.valid)
    else $error("output valid after reset");

  // While stalled, the last gain stage keeps its contents
  a_stall_keeps_stage: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable({v6, ax6, ay6, nx6, ny6, t6}))
    else $error("pipeline stage changed during stall");

endmodule
`default_nettype wire
